/* sv/oba_pkg.sv */
// Shared types and constants for the OHLC bar aggregator.
package oba_pkg;

	localparam int TS_W        = 48;
	localparam int PRICE_W     = 32;
	localparam int QTY_W       = 48;
	localparam int SUM_W       = 56;
	localparam int GSIZE_W     = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [GSIZE_W-1:0] GROUP_SIZE_RESET = GSIZE_W'(3);
	localparam logic [SUM_W-1:0]   SUM_MAX          = {SUM_W{1'b1}};

	typedef struct packed {
		logic [TS_W-1:0]    timestamp;
		logic [PRICE_W-1:0] open_price;
		logic [PRICE_W-1:0] high_price;
		logic [PRICE_W-1:0] low_price;
		logic [PRICE_W-1:0] close_price;
		logic [QTY_W-1:0]   trade_amount;
		logic [QTY_W-1:0]   trade_volume;
		logic               end_of_list;
	} candle_t;

	typedef struct packed {
		logic [TS_W-1:0]    bar_timestamp;
		logic [PRICE_W-1:0] bar_open;
		logic [PRICE_W-1:0] bar_high;
		logic [PRICE_W-1:0] bar_low;
		logic [PRICE_W-1:0] bar_close;
		logic [SUM_W-1:0]   bar_amount;
		logic [SUM_W-1:0]   bar_volume;
		logic               has_data;
	} bar_t;

	typedef struct packed {
		candle_t candle;
		logic    good;
		logic    close_group;
	} entry_t;

endpackage

/* sv/oba_front.sv */
// Front end: group size register, group position counter and candle classification.
module oba_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic [oba_pkg::GSIZE_W-1:0] cfg_data,
	input  logic                     accept,
	input  oba_pkg::candle_t         candle,
	output oba_pkg::entry_t          entry
);
	import oba_pkg::*;

	logic [GSIZE_W-1:0] group_size_q;
	logic [GSIZE_W-1:0] position_q;
	logic [GSIZE_W-1:0] size_eff;
	logic               complete;

	assign size_eff = (group_size_q == '0) ? GSIZE_W'(1) : group_size_q;
	assign complete = ({1'b0, position_q} + (GSIZE_W+1)'(1)) >= {1'b0, size_eff};

	always_comb begin
		entry.candle      = candle;
		entry.good        = (candle.open_price != '0) && (candle.high_price != '0)
			&& (candle.low_price != '0) && (candle.close_price != '0);
		entry.close_group = complete;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= GROUP_SIZE_RESET;
			position_q   <= '0;
		end else begin
			if (cfg_valid) begin
				group_size_q <= cfg_data;
			end
			if (accept) begin
				if (complete || candle.end_of_list) begin
					position_q <= '0;
				end else begin
					position_q <= position_q + GSIZE_W'(1);
				end
			end
		end
	end

endmodule

/* sv/oba_queue.sv */
// Short first-in first-out queue between the front end and the accumulator.
module oba_queue #(
	parameter int DEPTH = oba_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  oba_pkg::entry_t push_data,
	input  logic            pop,
	output logic            full,
	output logic            nonempty,
	output oba_pkg::entry_t head
);
	import oba_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t         slots_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign head     = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

/* sv/oba_back.sv */
// Back end: bar accumulator with saturating sums and the output register.
module oba_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_nonempty,
	input  oba_pkg::entry_t head,
	output logic            pop,
	output logic            bar_valid,
	input  logic            bar_stall,
	output oba_pkg::bar_t   bar
);
	import oba_pkg::*;

	logic [TS_W-1:0]    acc_ts_q;
	logic [PRICE_W-1:0] acc_open_q;
	logic [PRICE_W-1:0] acc_high_q;
	logic [PRICE_W-1:0] acc_low_q;
	logic [PRICE_W-1:0] acc_close_q;
	logic [SUM_W-1:0]   acc_amount_q;
	logic [SUM_W-1:0]   acc_volume_q;
	logic               acc_seen_q;
	logic               bar_valid_q;
	bar_t               bar_q;
	bar_t               nxt;
	logic [SUM_W:0]     amount_sum;
	logic [SUM_W:0]     volume_sum;
	logic               slot_free;

	assign slot_free = !bar_valid_q || !bar_stall;
	assign pop       = q_nonempty && slot_free;
	assign bar_valid = bar_valid_q;
	assign bar       = bar_q;

	assign amount_sum = {1'b0, acc_amount_q} + (SUM_W+1)'(head.candle.trade_amount);
	assign volume_sum = {1'b0, acc_volume_q} + (SUM_W+1)'(head.candle.trade_volume);

	always_comb begin
		nxt.bar_timestamp = acc_ts_q;
		nxt.bar_open      = acc_open_q;
		nxt.bar_high      = acc_high_q;
		nxt.bar_low       = acc_low_q;
		nxt.bar_close     = acc_close_q;
		nxt.bar_amount    = acc_amount_q;
		nxt.bar_volume    = acc_volume_q;
		nxt.has_data      = acc_seen_q;
		if (head.good) begin
			if (!acc_seen_q) begin
				nxt.bar_timestamp = head.candle.timestamp;
				nxt.bar_open      = head.candle.open_price;
				nxt.bar_high      = head.candle.high_price;
				nxt.bar_low       = head.candle.low_price;
			end else begin
				if (head.candle.high_price > acc_high_q) begin
					nxt.bar_high = head.candle.high_price;
				end
				if (head.candle.low_price < acc_low_q) begin
					nxt.bar_low = head.candle.low_price;
				end
			end
			nxt.bar_close  = head.candle.close_price;
			nxt.bar_amount = amount_sum[SUM_W] ? SUM_MAX : amount_sum[SUM_W-1:0];
			nxt.bar_volume = volume_sum[SUM_W] ? SUM_MAX : volume_sum[SUM_W-1:0];
			nxt.has_data   = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.close_group) begin
			bar_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_valid_q  <= 1'b0;
			acc_ts_q     <= '0;
			acc_open_q   <= '0;
			acc_high_q   <= '0;
			acc_low_q    <= '0;
			acc_close_q  <= '0;
			acc_amount_q <= '0;
			acc_volume_q <= '0;
			acc_seen_q   <= 1'b0;
		end else begin
			if (bar_valid_q && !bar_stall) begin
				bar_valid_q <= 1'b0;
			end
			if (pop) begin
				if (head.close_group) begin
					bar_valid_q <= 1'b1;
				end
				if (head.close_group || head.candle.end_of_list) begin
					acc_ts_q     <= '0;
					acc_open_q   <= '0;
					acc_high_q   <= '0;
					acc_low_q    <= '0;
					acc_close_q  <= '0;
					acc_amount_q <= '0;
					acc_volume_q <= '0;
					acc_seen_q   <= 1'b0;
				end else begin
					acc_ts_q     <= nxt.bar_timestamp;
					acc_open_q   <= nxt.bar_open;
					acc_high_q   <= nxt.bar_high;
					acc_low_q    <= nxt.bar_low;
					acc_close_q  <= nxt.bar_close;
					acc_amount_q <= nxt.bar_amount;
					acc_volume_q <= nxt.bar_volume;
					acc_seen_q   <= nxt.has_data;
				end
			end
		end
	end

endmodule

/* sv/ohlc_bar_aggregator.sv */
// Top level of the OHLC bar aggregator: front end, queue and accumulator.
// The block takes one base candle per clock cycle while its queue has room and
// emits one merged bar after every group of group_size candles; the front end
// counts group positions and classifies each candle, and a queue of QUEUE_DEPTH
// words decouples it from the accumulator, so the sustained rate is one candle
// per cycle while the bar output is not stalled. A bar is registered as the
// candle that completes its group leaves the queue. The group size register
// is written through the configuration channel, which is always ready, and
// must only change while no candles are in flight.
module ohlc_bar_aggregator #(
	parameter int QUEUE_DEPTH = oba_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        candle_valid,
	output logic                        candle_stall,
	input  oba_pkg::candle_t            candle,
	output logic                        bar_valid,
	input  logic                        bar_stall,
	output oba_pkg::bar_t               bar,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [oba_pkg::GSIZE_W-1:0] cfg_data
);
	import oba_pkg::*;

	entry_t front_entry;
	entry_t q_head;
	logic   q_full;
	logic   q_nonempty;
	logic   q_pop;
	logic   accept;

	assign cfg_ready    = 1'b1;
	assign candle_stall = q_full;
	assign accept       = candle_valid && !q_full;

	oba_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.accept   (accept),
		.candle   (candle),
		.entry    (front_entry)
	);

	oba_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_data(front_entry),
		.pop      (q_pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (q_head)
	);

	oba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_nonempty(q_nonempty),
		.head      (q_head),
		.pop       (q_pop),
		.bar_valid (bar_valid),
		.bar_stall (bar_stall),
		.bar       (bar)
	);

`ifndef SYNTHESIS
	a_empty_bar_zero: assert property (@(posedge clk) disable iff (!arst_n)
		bar_valid && !bar.has_data |-> bar.bar_timestamp == '0 && bar.bar_open == '0
			&& bar.bar_high == '0 && bar.bar_low == '0 && bar.bar_close == '0
			&& bar.bar_amount == '0 && bar.bar_volume == '0)
		else $error("empty bar carries nonzero fields");

	a_data_bar_prices: assert property (@(posedge clk) disable iff (!arst_n)
		bar_valid && bar.has_data |-> bar.bar_open != '0 && bar.bar_low != '0
			&& bar.bar_high != '0 && bar.bar_close != '0)
		else $error("bar with data has a zero price");

	a_group_close_emits: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_head.close_group |=> bar_valid)
		else $error("completed group produced no bar");
`endif

endmodule

/* tb/ohlc_bar_aggregator_tb.sv */
// Self-checking testbench for the OHLC bar aggregator with its own bar predictor.
module ohlc_bar_aggregator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import oba_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_PCT    = 38;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               candle_valid = 1'b0;
	logic               candle_stall;
	candle_t            candle       = '0;
	logic               bar_valid;
	logic               bar_stall    = 1'b0;
	bar_t               bar;
	logic               cfg_valid    = 1'b0;
	logic               cfg_ready;
	logic [GSIZE_W-1:0] cfg_data     = '0;

	candle_t            candles_pending[$];
	bar_t               bars_due[$];
	bar_t               run_bar      = '0;
	logic [GSIZE_W-1:0] grp_pos      = '0;
	logic [GSIZE_W-1:0] size_reg     = GROUP_SIZE_RESET;
	bit                 candle_took  = 1'b0;
	bit                 calm         = 1'b0;
	bit                 hold_arm     = 1'b0;
	bit                 hold_done    = 1'b0;
	int                 hold_left    = 0;
	int                 mismatches   = 0;

	ohlc_bar_aggregator u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.candle_valid(candle_valid),
		.candle_stall(candle_stall),
		.candle      (candle),
		.bar_valid   (bar_valid),
		.bar_stall   (bar_stall),
		.bar         (bar),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [SUM_W-1:0] sat_sum(input logic [SUM_W-1:0] acc,
			input logic [QTY_W-1:0] qty);
		logic [SUM_W:0] s;
		s = {1'b0, acc} + qty;
		return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
	endfunction

	function automatic bit merge_candle(input candle_t c, output bar_t b);
		int span;
		bit emit;
		span = (size_reg == 0) ? 1 : int'(size_reg);
		b = '0;
		if (c.open_price != 0 && c.high_price != 0 && c.low_price != 0 &&
				c.close_price != 0) begin
			if (!run_bar.has_data) begin
				run_bar.bar_timestamp = c.timestamp;
				run_bar.bar_open      = c.open_price;
				run_bar.bar_high      = c.high_price;
				run_bar.bar_low       = c.low_price;
				run_bar.has_data      = 1'b1;
			end else begin
				if (c.high_price > run_bar.bar_high)
					run_bar.bar_high = c.high_price;
				if (c.low_price < run_bar.bar_low)
					run_bar.bar_low = c.low_price;
			end
			run_bar.bar_close  = c.close_price;
			run_bar.bar_amount = sat_sum(run_bar.bar_amount, c.trade_amount);
			run_bar.bar_volume = sat_sum(run_bar.bar_volume, c.trade_volume);
		end
		emit = (int'(grp_pos) + 1 >= span);
		if (emit) begin
			b = run_bar;
			run_bar = '0;
			grp_pos = '0;
		end else begin
			grp_pos = grp_pos + 1'b1;
		end
		if (c.end_of_list) begin
			run_bar = '0;
			grp_pos = '0;
		end
		return emit;
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic compare_bar(input bar_t got, input bar_t want);
		if (got.bar_timestamp !== want.bar_timestamp)
			flag_mismatch("bar_timestamp", got.bar_timestamp, want.bar_timestamp);
		if (got.bar_open !== want.bar_open)
			flag_mismatch("bar_open", got.bar_open, want.bar_open);
		if (got.bar_high !== want.bar_high)
			flag_mismatch("bar_high", got.bar_high, want.bar_high);
		if (got.bar_low !== want.bar_low)
			flag_mismatch("bar_low", got.bar_low, want.bar_low);
		if (got.bar_close !== want.bar_close)
			flag_mismatch("bar_close", got.bar_close, want.bar_close);
		if (got.bar_amount !== want.bar_amount)
			flag_mismatch("bar_amount", got.bar_amount, want.bar_amount);
		if (got.bar_volume !== want.bar_volume)
			flag_mismatch("bar_volume", got.bar_volume, want.bar_volume);
		if (got.has_data !== want.has_data)
			flag_mismatch("has_data", got.has_data, want.has_data);
	endtask

	function automatic logic [PRICE_W-1:0] pick_price();
		int r;
		r = $urandom_range(99);
		if (r < 7)
			return '0;
		if (r < 12)
			return '1;
		if (r < 17)
			return PRICE_W'($urandom_range(3, 1));
		return $urandom;
	endfunction

	function automatic logic [QTY_W-1:0] pick_qty(input int max_pct);
		int r;
		r = $urandom_range(99);
		if (r < max_pct)
			return '1;
		if (r < max_pct + 5)
			return '0;
		return QTY_W'({$urandom, $urandom});
	endfunction

	function automatic candle_t rand_candle(input int eol_pct, input int max_pct);
		candle_t c;
		c.timestamp    = TS_W'({$urandom, $urandom});
		c.open_price   = pick_price();
		c.high_price   = pick_price();
		c.low_price    = pick_price();
		c.close_price  = pick_price();
		c.trade_amount = pick_qty(max_pct);
		c.trade_volume = pick_qty(max_pct);
		c.end_of_list  = ($urandom_range(99) < eol_pct);
		return c;
	endfunction

	function automatic candle_t make_candle(input logic [TS_W-1:0] ts,
			input logic [PRICE_W-1:0] o, input logic [PRICE_W-1:0] h,
			input logic [PRICE_W-1:0] l, input logic [PRICE_W-1:0] cl,
			input logic [QTY_W-1:0] am, input logic [QTY_W-1:0] vo, input logic eol);
		candle_t c;
		c.timestamp    = ts;
		c.open_price   = o;
		c.high_price   = h;
		c.low_price    = l;
		c.close_price  = cl;
		c.trade_amount = am;
		c.trade_volume = vo;
		c.end_of_list  = eol;
		return c;
	endfunction

	task automatic stage_candle(input candle_t c);
		candles_pending.insert(candles_pending.size(), c);
	endtask

	task automatic add_candles(input int n, input int eol_pct, input int max_pct);
		repeat (n)
			stage_candle(rand_candle(eol_pct, max_pct));
	endtask

	task automatic settle();
		while (candles_pending.size() != 0 || candle_valid || bars_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_group_size(input logic [GSIZE_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (arst_n && (!candle_valid || candle_took)) begin
			if (candles_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				candle       <= candles_pending.pop_front();
				candle_valid <= 1'b1;
			end else begin
				candle_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			bar_stall <= 1'b1;
		end else if (hold_arm && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			bar_stall <= 1'b1;
		end else begin
			bar_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		bar_t want;
		candle_took = candle_valid && !candle_stall;
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				size_reg = cfg_data;
			if (candle_took && merge_candle(candle, want))
				bars_due.insert(bars_due.size(), want);
			if (bar_valid && !bar_stall) begin
				if (bars_due.size() == 0) begin
					flag_mismatch("bar with nothing expected", bar.bar_timestamp, '0);
				end else begin
					want = bars_due.pop_front();
					compare_bar(bar, want);
				end
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((candle_valid && !candle_stall) || (bar_valid && !bar_stall) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int sizes[11];
		sizes = '{1, 2, 3, 5, 7, 16, 0, 4, 2, 1, 3};
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Group size still at its reset value of three.
		stage_candle(make_candle('1, '1, '1, '1, '1, '1, '1, 1'b0));
		stage_candle(make_candle('0, 1, 1, 1, 1, '0, '0, 1'b0));
		stage_candle(make_candle(5, 0, 9, 9, 9, 7, 7, 1'b0));
		stage_candle(make_candle(1, 5, 0, 5, 5, 1, 1, 1'b0));
		stage_candle(make_candle(2, 5, 5, 0, 5, 1, 1, 1'b0));
		stage_candle(make_candle(3, 5, 5, 5, 0, 1, 1, 1'b0));
		stage_candle(make_candle(10, 0, 0, 0, 0, 9, 9, 1'b0));
		stage_candle(make_candle(11, 100, 200, 50, 150, 3, 4, 1'b0));
		stage_candle(make_candle(12, 90, 300, 40, 80, 5, 6, 1'b0));
		stage_candle(make_candle(20, 7, 8, 6, 7, 2, 2, 1'b0));
		stage_candle(make_candle(21, 7, 9, 5, 8, 2, 2, 1'b1));
		stage_candle(make_candle(30, 4, 6, 3, 5, 1, 1, 1'b0));
		stage_candle(make_candle(31, 5, 7, 2, 6, 1, 1, 1'b0));
		stage_candle(make_candle(32, 6, 8, 4, 7, 1, 1, 1'b1));
		settle();

		set_group_size('0);
		stage_candle(make_candle(40, 3, 4, 2, 3, 1, 1, 1'b0));
		stage_candle(make_candle(41, 0, 4, 2, 3, 1, 1, 1'b0));
		stage_candle(make_candle(42, 3, 4, 2, 3, 1, 1, 1'b1));
		settle();
		set_group_size(1);
		stage_candle(make_candle(50, '1, '1, 1, '1, '1, '1, 1'b0));
		stage_candle(make_candle(51, 1, 1, '1, 1, 0, 0, 1'b0));
		settle();

		// The size drops to the number of candles already in a partial group.
		set_group_size(4);
		stage_candle(make_candle(60, 8, 9, 7, 8, 1, 1, 1'b0));
		stage_candle(make_candle(61, 8, 9, 7, 8, 1, 1, 1'b0));
		settle();
		set_group_size(2);
		stage_candle(make_candle(62, 8, 10, 6, 9, 1, 1, 1'b0));
		settle();

		foreach (sizes[i]) begin
			calm = (i == 3);
			set_group_size(GSIZE_W'(sizes[i]));
			add_candles(65, 5, 5);
			settle();
		end
		calm = 1'b0;

		// The output is held off long enough for the input to back up.
		set_group_size(1);
		hold_arm = 1'b1;
		add_candles(150, 5, 5);
		settle();

		set_group_size('1);
		add_candles(10, 0, 5);
		settle();
		set_group_size(4);
		add_candles(30, 5, 5);
		stage_candle(rand_candle(100, 5));
		settle();

		// One long group with mostly full-scale quantities, so both sums saturate.
		set_group_size(500);
		add_candles(499, 0, 90);
		stage_candle(rand_candle(100, 90));
		settle();
		set_group_size(3);
		add_candles(30, 5, 5);
		settle();

		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* filelist.f */
sv/oba_pkg.sv
sv/oba_front.sv
sv/oba_queue.sv
sv/oba_back.sv
sv/ohlc_bar_aggregator.sv
tb/ohlc_bar_aggregator_tb.sv
